// File: hw/rtl/cvfr_pkg.sv
// ----------------------------------------------------------------------------
// cvfr_pkg
// Shared types and constants of the CAN voice frame reassembler: the
// classified command passed from front to back and the fixed field widths.
// ----------------------------------------------------------------------------
package cvfr_pkg;

    // Fixed field widths
    localparam int LEN_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 5;
    localparam int PAYLOAD_N  = 7;   // data bytes 1..7
    localparam int NBYTES_W   = 3;   // 0..7 bytes appended per packet
    localparam int CFG_IDX_W  = 2;
    localparam int PKT_W      = 3;

    // Frame rules
    localparam logic [LEN_W-1:0] MAX_LEN       = 4'd8;
    localparam logic [PKT_W-1:0] FRAME_PACKETS = 3'd3;
    localparam logic [PKT_W-1:0] PACKET_SAT    = 3'd4;

    // Command queue depth between front and back
    localparam int QDEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_ID  = 2'd2;

    // Reset values of the packet type registers
    localparam logic [BYTE_W-1:0] RST_FIRST_ID  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_SECOND_ID = 8'd2;
    localparam logic [BYTE_W-1:0] RST_THIRD_ID  = 8'd3;

    // Command kinds
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FINAL  = 2'd2
    } t_op;

    // One classified packet
    typedef struct packed {
        t_op                                op;
        logic [NBYTES_W-1:0]                nbytes;
        logic [PAYLOAD_N-1:0][BYTE_W-1:0]   bytes;   // bytes[0] is data byte 1
    } t_cmd;

    // Front to queue push
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

endpackage

// File: hw/rtl/can_voice_frame_reassembler.sv
// The back end pops a packet while idle and writes its payload bytes (up to 7)
// one per cycle; a final packet then passes a check state, and a completed frame
// drains FRAME_BYTES bytes via the output register, one per cycle unless stalled.
// The front takes a frame whenever the 2-entry command queue has room.
// Synchronous active-low reset clears counts and queue and restores type ids
// 1, 2, 3; the frame store is not cleared.
// ----------------------------------------------------------------------------
// can_voice_frame_reassembler
// Reassembles three CAN voice packets into one frame and streams its bytes.
// ----------------------------------------------------------------------------
module can_voice_frame_reassembler #(
    parameter int FRAME_BYTES = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cvfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cvfr_pkg::BYTE_W-1:0]        i_cfg_data,
    // received CAN frames
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] frame_length, [11:4] data_byte_1 ... [59:52] data_byte_7, [63:60] zero
    input  logic [63:0]                        s_axis_tdata,
    // [7:0] data_byte_0 (packet type)
    input  logic [7:0]                         s_axis_tuser,
    // frame bytes
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] frame_byte, [12:8] byte_position, [15:13] zero
    output logic [15:0]                        m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int QCW = $clog2(cvfr_pkg::QDEPTH + 1);

    logic [cvfr_pkg::PAYLOAD_N-1:0][cvfr_pkg::BYTE_W-1:0] payload;
    cvfr_pkg::t_push             push;
    cvfr_pkg::t_cmd              q_cmd;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic [QCW-1:0]              q_count;
    logic [cvfr_pkg::BYTE_W-1:0] frame_byte;
    logic [cvfr_pkg::POS_W-1:0]  byte_position;

    // Unpack payload bytes 1..7
    always_comb begin
        for (int i = 0; i < cvfr_pkg::PAYLOAD_N; i++) begin
            payload[i] = s_axis_tdata[cvfr_pkg::LEN_W + i*cvfr_pkg::BYTE_W +: cvfr_pkg::BYTE_W];
        end
    end

    cvfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_frame_length (s_axis_tdata[cvfr_pkg::LEN_W-1:0]),
        .i_type         (s_axis_tuser),
        .i_payload      (payload),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    cvfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_count (q_count)
    );

    cvfr_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_frame_byte    (frame_byte),
        .o_byte_position (byte_position),
        .o_last_byte     (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, byte_position, frame_byte};

    // Queue never takes a command while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> (q_count != QCW'(cvfr_pkg::QDEPTH)))
        else $error("command pushed into full queue");

    // An accepted frame lands in the queue
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (q_count != '0))
        else $error("accepted frame missing from queue");

    // Last byte carries the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast)
            |-> (byte_position == cvfr_pkg::POS_W'(FRAME_BYTES - 1)))
        else $error("last byte at wrong position");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// File: hw/rtl/cvfr_ram.sv
// ----------------------------------------------------------------------------
// cvfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cvfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cvfr_front.sv
// ----------------------------------------------------------------------------
// cvfr_front
// Holds the packet type registers, accepts CAN frames and classifies each
// into a clear, append or final command for the back end.
// ----------------------------------------------------------------------------
module cvfr_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [cvfr_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [cvfr_pkg::BYTE_W-1:0]             i_cfg_data,
    // incoming frames
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [cvfr_pkg::LEN_W-1:0]              i_frame_length,
    input  logic [cvfr_pkg::BYTE_W-1:0]             i_type,
    input  logic [cvfr_pkg::PAYLOAD_N-1:0][cvfr_pkg::BYTE_W-1:0] i_payload,
    // queue side
    input  logic                                    i_q_full,
    output cvfr_pkg::t_push                         o_push
);

    logic [cvfr_pkg::BYTE_W-1:0] r_first_id;
    logic [cvfr_pkg::BYTE_W-1:0] r_second_id;
    logic [cvfr_pkg::BYTE_W-1:0] r_third_id;

    logic [cvfr_pkg::LEN_W-1:0]  len_clamped;
    cvfr_pkg::t_cmd              cmd;

    // Update type registers on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id  <= cvfr_pkg::RST_FIRST_ID;
            r_second_id <= cvfr_pkg::RST_SECOND_ID;
            r_third_id  <= cvfr_pkg::RST_THIRD_ID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cvfr_pkg::CFG_FIRST_ID:  r_first_id  <= i_cfg_data;
                cvfr_pkg::CFG_SECOND_ID: r_second_id <= i_cfg_data;
                cvfr_pkg::CFG_THIRD_ID:  r_third_id  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the length code to eight bytes
    assign len_clamped = (i_frame_length > cvfr_pkg::MAX_LEN) ? cvfr_pkg::MAX_LEN
                                                              : i_frame_length;

    // Classify: first and second take precedence over third
    always_comb begin
        cmd.bytes  = i_payload;
        cmd.op     = cvfr_pkg::OP_CLEAR;
        cmd.nbytes = '0;
        priority if (len_clamped == '0) begin
            cmd.op = cvfr_pkg::OP_CLEAR;
        end else if (i_type == r_first_id || i_type == r_second_id) begin
            cmd.op     = cvfr_pkg::OP_APPEND;
            cmd.nbytes = cvfr_pkg::NBYTES_W'(len_clamped - 4'd1);
        end else if (i_type == r_third_id) begin
            // last byte of the final packet is reserved
            cmd.op     = cvfr_pkg::OP_FINAL;
            cmd.nbytes = (len_clamped < 4'd2) ? '0
                                              : cvfr_pkg::NBYTES_W'(len_clamped - 4'd2);
        end else begin
            cmd.op = cvfr_pkg::OP_CLEAR;
        end
    end

    assign o_ready     = !i_q_full;
    assign o_push.push = i_valid && !i_q_full;
    assign o_push.cmd  = cmd;

endmodule

// File: hw/rtl/cvfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// cvfr_cmd_queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module cvfr_cmd_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  cvfr_pkg::t_push                          i_push,
    output logic                                     o_full,
    output logic                                     o_valid,
    output cvfr_pkg::t_cmd                           o_cmd,
    input  logic                                     i_pop,
    output logic [$clog2(cvfr_pkg::QDEPTH+1)-1:0]    o_count
);

    localparam int PW = $clog2(cvfr_pkg::QDEPTH);
    localparam int CW = $clog2(cvfr_pkg::QDEPTH+1);

    cvfr_pkg::t_cmd  r_mem [cvfr_pkg::QDEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(cvfr_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign o_count = r_cnt;

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(cvfr_pkg::QDEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(cvfr_pkg::QDEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

endmodule

// File: hw/rtl/cvfr_back.sv
// ----------------------------------------------------------------------------
// cvfr_back
// Carries out queued commands: appends payload bytes to the frame store one
// per cycle, checks a finished run, and drains a complete frame to the
// output register.
// ----------------------------------------------------------------------------
module cvfr_back #(
    parameter int FRAME_BYTES = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command queue
    input  logic                          i_q_valid,
    input  cvfr_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    // result stream
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cvfr_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic [cvfr_pkg::POS_W-1:0]    o_byte_position,
    output logic                          o_last_byte
);

    localparam int AW = $clog2(FRAME_BYTES);       // store address
    localparam int WW = $clog2(FRAME_BYTES + 2);   // write count, saturates at +1
    localparam int RW = $clog2(FRAME_BYTES + 1);   // drain counter, reaches depth

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_APPEND = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_DRAIN  = 4'b1000
    } t_state;

    t_state                                           r_state, n_state;
    logic [WW-1:0]                                    r_wc, n_wc;
    logic [cvfr_pkg::PKT_W-1:0]                       r_pc, n_pc;
    logic [cvfr_pkg::PAYLOAD_N-1:0][cvfr_pkg::BYTE_W-1:0] r_bytes, n_bytes;
    logic [cvfr_pkg::NBYTES_W-1:0]                    r_idx, n_idx;
    logic [cvfr_pkg::NBYTES_W-1:0]                    r_cnt, n_cnt;
    logic                                             r_final, n_final;
    logic [RW-1:0]                                    r_rd, n_rd;
    logic                                             r_pend, n_pend;
    logic [AW-1:0]                                    r_pend_addr, n_pend_addr;
    logic                                             r_out_valid, n_out_valid;
    logic [cvfr_pkg::BYTE_W-1:0]                      r_out_byte;
    logic [cvfr_pkg::POS_W-1:0]                       r_out_pos;
    logic                                             r_out_last;

    logic                          ram_we;
    logic [cvfr_pkg::BYTE_W-1:0]   ram_rdata;
    logic                          issue;
    logic                          can_load;
    logic                          load;
    logic                          complete;

    // Frame store
    cvfr_ram #(
        .WIDTH (cvfr_pkg::BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wc[AW-1:0]),
        .i_wdata (r_bytes[r_idx]),
        .i_re    (issue),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign can_load = !r_out_valid || i_ready;
    assign load     = r_pend && can_load;
    assign complete = (r_pc == cvfr_pkg::FRAME_PACKETS) && (r_wc == WW'(FRAME_BYTES));
    assign ram_we   = (r_state == ST_APPEND) && (r_wc < WW'(FRAME_BYTES));
    assign issue    = (r_state == ST_DRAIN) && (r_rd != RW'(FRAME_BYTES))
                      && (!r_pend || can_load);

    // Sequence commands
    always_comb begin
        n_state = r_state;
        n_wc    = r_wc;
        n_pc    = r_pc;
        n_bytes = r_bytes;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_final = r_final;
        n_rd    = r_rd;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.op == cvfr_pkg::OP_CLEAR) begin
                        n_wc = '0;
                        n_pc = '0;
                    end else begin
                        if (r_pc != cvfr_pkg::PACKET_SAT) begin
                            n_pc = r_pc + 1'b1;
                        end
                        n_bytes = i_q_cmd.bytes;
                        n_cnt   = i_q_cmd.nbytes;
                        n_idx   = '0;
                        n_final = (i_q_cmd.op == cvfr_pkg::OP_FINAL);
                        priority if (i_q_cmd.nbytes != '0) begin
                            n_state = ST_APPEND;
                        end else if (i_q_cmd.op == cvfr_pkg::OP_FINAL) begin
                            n_state = ST_CHECK;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_APPEND: begin
                // one byte a cycle, drop past capacity, saturate the count
                if (r_wc != WW'(FRAME_BYTES + 1)) begin
                    n_wc = r_wc + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == r_cnt - 1'b1) begin
                    n_state = r_final ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK: begin
                n_wc = '0;
                n_pc = '0;
                n_rd = '0;
                n_state = complete ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                if (issue) begin
                    n_rd = r_rd + 1'b1;
                end
                if (r_rd == RW'(FRAME_BYTES) && !r_pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Track the read in flight and the output register
    always_comb begin
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_out_valid = r_out_valid;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_pend      = 1'b0;
        end
        if (issue) begin
            n_pend      = 1'b1;
            n_pend_addr = r_rd[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wc        <= '0;
            r_pc        <= '0;
            r_rd        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wc        <= n_wc;
            r_pc        <= n_pc;
            r_rd        <= n_rd;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bytes     <= n_bytes;
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_final     <= n_final;
        r_pend_addr <= n_pend_addr;
        if (load) begin
            r_out_byte <= ram_rdata;
            r_out_pos  <= cvfr_pkg::POS_W'(r_pend_addr);
            r_out_last <= (r_pend_addr == AW'(FRAME_BYTES - 1));
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_last_byte     = r_out_last;

endmodule

// File: sim/can_voice_frame_reassembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_voice_frame_reassembler_tb
// Streams CAN voice packets into the reassembler under several packet type
// settings and random gaps and stalls. It rebuilds every frame in its own
// model and compares each streamed frame byte with the oldest predicted one.
// ----------------------------------------------------------------------------
module can_voice_frame_reassembler_tb;

    localparam int FRAME_BYTES = 20;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_PKTS = 16;

    // One received CAN frame; pay[0] is data byte 1
    typedef struct packed {
        logic [cvfr_pkg::LEN_W-1:0]                                 len;
        logic [cvfr_pkg::BYTE_W-1:0]                                kind;
        logic [cvfr_pkg::PAYLOAD_N-1:0][cvfr_pkg::BYTE_W-1:0]       pay;
    } t_can_pkt;

    // One streamed frame byte
    typedef struct packed {
        logic [cvfr_pkg::BYTE_W-1:0] value;
        logic [cvfr_pkg::POS_W-1:0]  pos;
        logic                        last;
    } t_frame_byte;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [cvfr_pkg::CFG_IDX_W-1:0] i_cfg_idx = cvfr_pkg::CFG_FIRST_ID;
    logic [cvfr_pkg::BYTE_W-1:0]    i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata = '0;
    logic [7:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    can_voice_frame_reassembler #(
        .FRAME_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Model state
    logic [cvfr_pkg::BYTE_W-1:0] first_id = cvfr_pkg::RST_FIRST_ID;
    logic [cvfr_pkg::BYTE_W-1:0] second_id = cvfr_pkg::RST_SECOND_ID;
    logic [cvfr_pkg::BYTE_W-1:0] third_id = cvfr_pkg::RST_THIRD_ID;
    logic [cvfr_pkg::BYTE_W-1:0] store_copy [FRAME_BYTES];
    int                          bytes_written = 0;
    int                          packets_seen = 0;

    t_can_pkt    pkts_to_send [$];
    t_frame_byte frame_bytes_due [$];
    t_can_pkt    held_pkt;
    int          pkts_queued = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    bit          steady = 1'b0;
    bit          sending;

    // Short gaps mostly, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (steady || r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Copy payload bytes [1, stop) into the store, saturating the count
    function automatic void store_payload(input t_can_pkt p, input int stop);
        for (int i = 1; i < stop; i++) begin
            if (bytes_written < FRAME_BYTES)
                store_copy[bytes_written] = p.pay[i-1];
            if (bytes_written < FRAME_BYTES + 1)
                bytes_written++;
        end
    endfunction

    // Advance the frame model by one packet and queue any frame bytes it frees
    function automatic void reassemble_packet(input t_can_pkt p);
        int          n;
        bit          done;
        t_frame_byte fb;
        n = (p.len > cvfr_pkg::MAX_LEN) ? int'(cvfr_pkg::MAX_LEN) : int'(p.len);
        if (n == 0) begin
            bytes_written = 0;
            packets_seen = 0;
            return;
        end
        if (p.kind == first_id || p.kind == second_id) begin
            if (packets_seen < int'(cvfr_pkg::PACKET_SAT))
                packets_seen++;
            store_payload(p, n);
            return;
        end
        if (p.kind != third_id) begin
            bytes_written = 0;
            packets_seen = 0;
            return;
        end
        if (packets_seen < int'(cvfr_pkg::PACKET_SAT))
            packets_seen++;
        store_payload(p, n - 1);
        done = (packets_seen == int'(cvfr_pkg::FRAME_PACKETS))
               && (bytes_written == FRAME_BYTES);
        bytes_written = 0;
        packets_seen = 0;
        if (done) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                fb.value = store_copy[i];
                fb.pos = 5'(i);
                fb.last = (i == FRAME_BYTES - 1);
                frame_bytes_due.push_back(fb);
            end
        end
    endfunction

    // Build one packet; fill 0 means random payload
    function automatic t_can_pkt make_pkt(input logic [7:0] kind, input int len,
                                          input logic [7:0] fill);
        t_can_pkt p;
        p.kind = kind;
        p.len = 4'(len);
        for (int i = 0; i < cvfr_pkg::PAYLOAD_N; i++)
            p.pay[i] = (fill == 8'h00) ? 8'($urandom_range(0, 255))
                                       : ((i % 2 == 0) ? fill : ~fill);
        return p;
    endfunction

    function automatic void push_pkt(input t_can_pkt p);
        pkts_to_send.push_back(p);
        pkts_queued++;
    endfunction

    function automatic logic [7:0] append_id();
        return ($urandom_range(0, 1) == 0) ? first_id : second_id;
    endfunction

    function automatic logic [7:0] unknown_id();
        logic [7:0] k;
        do k = 8'($urandom_range(0, 255));
        while (k == first_id || k == second_id || k == third_id);
        return k;
    endfunction

    // Wait until every packet is taken and every frame byte has come out
    task automatic wait_idle();
        while (pkts_to_send.size() > 0 || s_axis_tvalid || frame_bytes_due.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all three type registers, one per cycle
    task automatic write_ids(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= cvfr_pkg::CFG_FIRST_ID;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_idx <= cvfr_pkg::CFG_SECOND_ID;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_idx <= cvfr_pkg::CFG_THIRD_ID;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        first_id = a;
        second_id = b;
        third_id = c;
    endtask

    // Packet driver: hold a word until taken, then idle a random while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            sending = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                reassemble_packet(held_pkt);
                sending = 1'b0;
                send_gap = idle_len();
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pkts_to_send.size() > 0) begin
                    held_pkt = pkts_to_send.pop_front();
                    s_axis_tdata <= {4'h0, held_pkt.pay, held_pkt.len};
                    s_axis_tuser <= held_pkt.kind;
                    sending = 1'b1;
                end
            end
            s_axis_tvalid <= sending;
        end
    end

    // Frame byte monitor: check each taken word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected frame byte: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    t_frame_byte fb;
                    fb = frame_bytes_due.pop_front();
                    if (m_axis_tdata[7:0] !== fb.value || m_axis_tdata[12:8] !== fb.pos ||
                        m_axis_tlast !== fb.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"frame byte mismatch: expected byte %h pos %0d last %b,",
                                      " got byte %h pos %0d last %b"},
                                     fb.value, fb.pos, fb.last, m_axis_tdata[7:0],
                                     m_axis_tdata[12:8], m_axis_tlast);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Limit on the whole run
    initial begin
        #1500000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus and phase control
    initial begin
        int target;
        int r;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset ids: zero length, extreme payloads, long length codes
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 0, 8'hFF));
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'h00));
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 8, 8'hFF));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 8, 8'hAA));
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 9, 8'h55));
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 12, 8'h0F));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 15, 8'hF0));
        // Third packet with length one stores nothing
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'h11));
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 8, 8'h22));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 1, 8'h33));
        // First packet keeps the index: four packets overfill the store
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'h44));
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'h66));
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 8, 8'h77));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 8, 8'h88));
        // Second before first still completes
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 8, 8'h99));
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'hBB));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 8, 8'hCC));
        // Unknown type drops a partial frame
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'hDD));
        push_pkt(make_pkt(8'hFF, 8, 8'hEE));
        push_pkt(make_pkt(cvfr_pkg::RST_SECOND_ID, 8, 8'h01));
        push_pkt(make_pkt(cvfr_pkg::RST_FIRST_ID, 8, 8'h02));
        push_pkt(make_pkt(cvfr_pkg::RST_THIRD_ID, 8, 8'h04));

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: write_ids(8'd0, 8'd255, 8'd128);
                    2: write_ids(8'd255, 8'd0, 8'd0);
                    3: write_ids(8'h5A, 8'hC3, 8'h5A);
                    default: begin
                        logic [7:0] a, b, c;
                        a = 8'($urandom_range(0, 255));
                        do b = 8'($urandom_range(0, 255)); while (b == a);
                        do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
                        write_ids(a, b, c);
                    end
                endcase
                @(negedge i_clk);
            end
            steady = (phase == 1);
            // Shared ids: second wins over third, first wins over third
            if (phase == 2 || phase == 3) begin
                push_pkt(make_pkt(second_id, 8, 8'h3C));
                push_pkt(make_pkt(first_id, 8, 8'hC3));
                push_pkt(make_pkt(third_id, 8, 8'h5A));
            end
            target = pkts_queued + PHASE_PKTS;
            while (pkts_queued < target) begin
                r = $urandom_range(0, 9);
                if (r <= 5) begin
                    if ($urandom_range(0, 1) == 0)
                        push_pkt(make_pkt(unknown_id(), $urandom_range(0, 15), 8'h00));
                    push_pkt(make_pkt(append_id(), $urandom_range(8, 15), 8'h00));
                    push_pkt(make_pkt(append_id(), $urandom_range(8, 15), 8'h00));
                    push_pkt(make_pkt(third_id, $urandom_range(8, 15), 8'h00));
                end else if (r == 6) begin
                    push_pkt(make_pkt(8'($urandom_range(0, 255)), $urandom_range(0, 15),
                                      8'h00));
                end else if (r == 7) begin
                    // short or malformed frame
                    push_pkt(make_pkt(append_id(), $urandom_range(1, 15), 8'h00));
                    push_pkt(make_pkt(append_id(), $urandom_range(1, 15), 8'h00));
                    push_pkt(make_pkt(third_id, $urandom_range(0, 15), 8'h00));
                end else if (r == 8) begin
                    push_pkt(make_pkt(append_id(), 8, 8'h00));
                    push_pkt(make_pkt(append_id(), 8, 8'h00));
                    push_pkt(make_pkt(append_id(), $urandom_range(1, 8), 8'h00));
                    push_pkt(make_pkt(third_id, 8, 8'h00));
                end else begin
                    push_pkt(make_pkt(($urandom_range(0, 1) == 0) ? third_id : unknown_id(),
                                      $urandom_range(0, 1) ? 0 : $urandom_range(0, 15),
                                      8'h00));
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
